/* sv/imu_sample_calibrate_scale_assert.svh */
// Assertion macros used by the checker file of the IMU sample calibrate and scale block.
// Depends on nothing; take it in with `include by bare file name.
`ifndef IMU_SAMPLE_CALIBRATE_SCALE_ASSERT_SVH
`define IMU_SAMPLE_CALIBRATE_SCALE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define IMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imc assertion failed");

// Next-cycle implication, off during reset.
`define IMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imc assertion failed");

// Next-cycle implication, live during reset.
`define IMC_ASSERT_NEXT_NORST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("imc assertion failed");

`endif

/* sv/imc_pkg.sv */
// Shared types, constants and helpers of the IMU sample calibrate and scale block.
// Depends on nothing; the lane, temperature, control and top-level files refer to it by scoped names.
package imc_pkg;

  localparam int unsigned CAL_RUN_LEN    = 100;
  localparam int unsigned TEMP_SENS_X100 = 33387;

  localparam int unsigned CNT_W = $clog2(CAL_RUN_LEN + 1);
  localparam int unsigned SUM_W = 17 + $clog2(CAL_RUN_LEN);

  localparam int unsigned AVG_N   = SUM_W - 1;
  localparam int unsigned AVG_S   = AVG_N + $clog2(CAL_RUN_LEN);
  localparam int unsigned AVG_R_W = AVG_N + 1;
  localparam int unsigned AVG_P_W = AVG_N + AVG_R_W;
  localparam int unsigned AVG_Q_W = AVG_P_W - AVG_S;
  localparam logic [AVG_R_W-1:0] AVG_RECIP =
    AVG_R_W'(((longint'(1) << AVG_S) + longint'(CAL_RUN_LEN) - 1) / longint'(CAL_RUN_LEN));

  localparam int unsigned TEMP_M_W   = 31;
  localparam int unsigned TEMP_S     = TEMP_M_W + $clog2(TEMP_SENS_X100);
  localparam int unsigned TEMP_R_W   = TEMP_M_W + 1;
  localparam int unsigned TEMP_P_W   = TEMP_M_W + TEMP_R_W;
  localparam int unsigned TEMP_Q_W   = TEMP_P_W - TEMP_S;
  localparam int unsigned TEMP_GAIN  = 25600;
  localparam int unsigned TEMP_HALF  = TEMP_SENS_X100 / 2;
  localparam int unsigned TEMP_BASE  = 21 * 256;
  localparam logic [TEMP_R_W-1:0] TEMP_RECIP =
    TEMP_R_W'(((longint'(1) << TEMP_S) + longint'(TEMP_SENS_X100) - 1) /
              longint'(TEMP_SENS_X100));

  localparam logic [15:0] RATE_RECIP [4] = '{16'd8005, 16'd16010, 16'd31969, 16'd63938};
  localparam logic [1:0]  ACCEL_SHIFT_MAX = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOM_TEMP   = 2'd2;

  typedef enum logic [1:0] {
    CMD_CONVERT,
    CMD_ACCEL,
    CMD_GYRO,
    CMD_MAG
  } imc_cmd_t;

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_ABS,
    CAL_MUL,
    CAL_WRITE
  } imc_cal_state_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } imc_adv_t;

  typedef struct packed {
    imc_cmd_t kind;
    logic     sample;
    logic     restart;
    logic     finish;
    logic     step_abs;
    logic     step_mul;
    logic     step_write;
  } imc_cal_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

/* sv/imc_lane.sv */
// One axis lane: offset correction, range scaling and calibration accumulators for one axis.
// Depends on imc_pkg.
module imc_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  imc_pkg::imc_adv_t     adv,
  input  imc_pkg::imc_cal_ctl_t ctl,
  input  logic [1:0]            accel_range,
  input  logic [1:0]            gyro_range,
  input  logic signed [15:0]    accel_raw,
  input  logic signed [15:0]    gyro_raw,
  input  logic signed [15:0]    mag_raw,
  output logic signed [15:0]    accel_val,
  output logic signed [15:0]    rate_val,
  output logic signed [15:0]    field_val
);

  logic signed [15:0] accel_off;
  logic signed [15:0] gyro_off;
  logic signed [15:0] mag_off;

  logic signed [15:0]               sample;
  logic signed [imc_pkg::SUM_W-1:0] sum;
  logic signed [imc_pkg::SUM_W-1:0] sum_next;
  logic signed [15:0]               min_val;
  logic signed [15:0]               min_next;
  logic signed [15:0]               max_val;
  logic signed [15:0]               max_next;

  logic signed [imc_pkg::SUM_W-1:0] fin_sum;
  logic signed [16:0]               fin_mid;
  logic                             fin_neg;
  logic [imc_pkg::AVG_N-1:0]        fin_abs;
  logic [imc_pkg::AVG_P_W-1:0]      fin_prod;
  logic [imc_pkg::AVG_Q_W-1:0]      avg_q;
  logic [15:0]                      avg_mag;
  logic signed [15:0]               avg_val;
  logic signed [16:0]               mid_adj;
  logic signed [15:0]               mid_val;

  logic [1:0]         accel_shift;
  logic signed [15:0] a1;
  logic signed [15:0] g1;
  logic signed [15:0] m1;
  logic signed [15:0] a2;
  logic signed [32:0] g_prod;
  logic signed [33:0] g2;
  logic signed [15:0] m2;
  logic signed [15:0] a3;
  logic signed [15:0] g3;
  logic signed [15:0] m3;

  always_comb begin
    case (ctl.kind)
      imc_pkg::CMD_ACCEL: sample = accel_raw;
      imc_pkg::CMD_GYRO:  sample = gyro_raw;
      default:            sample = mag_raw;
    endcase
    sum_next = (ctl.restart ? '0 : sum) + imc_pkg::SUM_W'(sample);
    min_next = (ctl.restart || (sample < min_val)) ? sample : min_val;
    max_next = (ctl.restart || (sample > max_val)) ? sample : max_val;

    avg_q   = fin_prod[imc_pkg::AVG_P_W-1:imc_pkg::AVG_S];
    avg_mag = 16'(avg_q);
    avg_val = fin_neg ? $signed(-avg_mag) : $signed(avg_mag);
    mid_adj = fin_mid + (fin_mid[16] ? 17'sd1 : 17'sd0);
    mid_val = mid_adj[16:1];

    accel_shift = imc_pkg::ACCEL_SHIFT_MAX - accel_range;
    g_prod      = g1 * $signed({1'b0, imc_pkg::RATE_RECIP[gyro_range]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      min_val   <= 16'sh7fff;
      max_val   <= 16'sh8000;
      accel_off <= '0;
      gyro_off  <= '0;
      mag_off   <= '0;
    end else begin
      if (ctl.sample) begin
        if (ctl.finish) begin
          sum     <= '0;
          min_val <= 16'sh7fff;
          max_val <= 16'sh8000;
        end else begin
          sum     <= sum_next;
          min_val <= min_next;
          max_val <= max_next;
        end
      end
      if (ctl.step_write) begin
        case (ctl.kind)
          imc_pkg::CMD_ACCEL: accel_off <= avg_val;
          imc_pkg::CMD_GYRO:  gyro_off  <= avg_val;
          imc_pkg::CMD_MAG:   mag_off   <= mid_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample && ctl.finish) begin
      fin_sum <= sum_next;
      fin_mid <= {max_next[15], max_next} + {min_next[15], min_next};
    end
    if (ctl.step_abs) begin
      fin_neg <= fin_sum[imc_pkg::SUM_W-1];
      fin_abs <= fin_sum[imc_pkg::SUM_W-1] ? imc_pkg::AVG_N'(-fin_sum)
                                           : imc_pkg::AVG_N'(fin_sum);
    end
    if (ctl.step_mul) begin
      fin_prod <= imc_pkg::AVG_P_W'(fin_abs) * imc_pkg::AVG_P_W'(imc_pkg::AVG_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      a1 <= imc_pkg::sat16(17'(accel_raw) - 17'(accel_off));
      g1 <= imc_pkg::sat16(17'(gyro_raw) - 17'(gyro_off));
      m1 <= imc_pkg::sat16(17'(mag_raw) - 17'(mag_off));
    end
    if (adv.s2) begin
      a2 <= a1 >>> accel_shift;
      g2 <= {g_prod[32], g_prod} + 34'sd32768;
      m2 <= m1;
    end
    if (adv.s3) begin
      a3 <= a2;
      g3 <= g2[31:16];
      m3 <= m2;
    end
  end

  assign accel_val = a3;
  assign rate_val  = g3;
  assign field_val = m3;

endmodule

/* sv/imc_temp.sv */
// Temperature lane: room offset removal and scaling to 1/256 degC by reciprocal multiply.
// Depends on imc_pkg.
module imc_temp (
  input  logic               clk,
  input  imc_pkg::imc_adv_t  adv,
  input  logic signed [15:0] temp_bias,
  input  logic signed [15:0] temp_raw,
  output logic signed [15:0] temp_val
);

  logic signed [16:0]                 d;
  logic                               t_neg1;
  logic                               t_neg2;
  logic                               t_neg3;
  logic [15:0]                        t_abs;
  logic [imc_pkg::TEMP_M_W-1:0]       t_m;
  logic [imc_pkg::TEMP_P_W-1:0]       t_p;
  logic [imc_pkg::TEMP_Q_W-1:0]       t_q;
  logic signed [imc_pkg::TEMP_Q_W+1:0] t_ext;
  logic signed [imc_pkg::TEMP_Q_W+1:0] t_sum;

  always_comb begin
    d     = 17'(temp_raw) - 17'(temp_bias);
    t_q   = t_p[imc_pkg::TEMP_P_W-1:imc_pkg::TEMP_S];
    t_ext = $signed({2'b00, t_q});
    t_sum = (t_neg3 ? -t_ext : t_ext) + (imc_pkg::TEMP_Q_W + 2)'(imc_pkg::TEMP_BASE);
    if (t_sum > 32767) begin
      temp_val = 16'sh7fff;
    end else if (t_sum < -32768) begin
      temp_val = 16'sh8000;
    end else begin
      temp_val = t_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      t_neg1 <= d[16];
      t_abs  <= d[16] ? 16'(-d) : 16'(d);
    end
    if (adv.s2) begin
      t_neg2 <= t_neg1;
      t_m    <= imc_pkg::TEMP_M_W'(t_abs) * imc_pkg::TEMP_M_W'(imc_pkg::TEMP_GAIN)
                + imc_pkg::TEMP_M_W'(imc_pkg::TEMP_HALF);
    end
    if (adv.s3) begin
      t_neg3 <= t_neg2;
      t_p    <= imc_pkg::TEMP_P_W'(t_m) * imc_pkg::TEMP_P_W'(imc_pkg::TEMP_RECIP);
    end
  end

endmodule

/* sv/imc_cal_ctrl.sv */
// Calibration run control: run kind, sample count and the offset divide sequencer.
// Depends on imc_pkg.
module imc_cal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            cmd,
  output imc_pkg::imc_cal_ctl_t ctl,
  output logic                  busy
);

  imc_pkg::imc_cmd_t       cmd_k;
  imc_pkg::imc_cmd_t       kind;
  imc_pkg::imc_cmd_t       kind_next;
  imc_pkg::imc_cmd_t       fin_kind;
  logic [imc_pkg::CNT_W-1:0] count;
  logic [imc_pkg::CNT_W-1:0] count_next;
  logic [imc_pkg::CNT_W-1:0] count_inc;
  imc_pkg::imc_cal_state_t state;
  imc_pkg::imc_cal_state_t state_next;
  logic                    sample;
  logic                    restart;
  logic                    finish;

  always_comb begin
    cmd_k     = imc_pkg::imc_cmd_t'(cmd);
    sample    = accept && (cmd_k != imc_pkg::CMD_CONVERT);
    restart   = (kind != cmd_k);
    count_inc = restart ? imc_pkg::CNT_W'(1) : count + imc_pkg::CNT_W'(1);
    finish    = sample && (count_inc >= imc_pkg::CNT_W'(imc_pkg::CAL_RUN_LEN));

    kind_next  = kind;
    count_next = count;
    if (sample) begin
      if (finish) begin
        kind_next  = imc_pkg::CMD_CONVERT;
        count_next = '0;
      end else begin
        kind_next  = cmd_k;
        count_next = count_inc;
      end
    end

    state_next = state;
    case (state)
      imc_pkg::CAL_IDLE:  if (finish) state_next = imc_pkg::CAL_ABS;
      imc_pkg::CAL_ABS:   state_next = imc_pkg::CAL_MUL;
      imc_pkg::CAL_MUL:   state_next = imc_pkg::CAL_WRITE;
      imc_pkg::CAL_WRITE: state_next = imc_pkg::CAL_IDLE;
      default:            state_next = imc_pkg::CAL_IDLE;
    endcase

    busy           = (state != imc_pkg::CAL_IDLE);
    ctl.kind       = busy ? fin_kind : cmd_k;
    ctl.sample     = sample;
    ctl.restart    = restart;
    ctl.finish     = finish;
    ctl.step_abs   = (state == imc_pkg::CAL_ABS);
    ctl.step_mul   = (state == imc_pkg::CAL_MUL);
    ctl.step_write = (state == imc_pkg::CAL_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imc_pkg::CAL_IDLE;
      kind  <= imc_pkg::CMD_CONVERT;
      count <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      fin_kind <= cmd_k;
    end
  end

endmodule

/* sv/imu_sample_calibrate_scale.sv */
// Top level of the IMU sample calibrate and scale block: config registers, lanes, output stage.
// Depends on imc_pkg, imc_lane, imc_temp and imc_cal_ctrl.
//
// Takes one nine-axis sample plus temperature per clock while in_ready is high and returns
// one corrected, scaled result per sample via the s1, s2, s3 and output registers; three
// axis lanes and a temperature lane work side by side and the output register gathers them.
// After the transaction that ends a calibration run, in_ready stays low through the ABS,
// MUL and WRITE states while each axis lane writes a new offset, the sum times a reciprocal
// or, for mag, the min/max midpoint; other samples go through at one per cycle while the
// output side accepts. Configuration writes are always accepted, taking effect next cycle.
module imu_sample_calibrate_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [imc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic signed [15:0]             accel_x,
  input  logic signed [15:0]             accel_y,
  input  logic signed [15:0]             accel_z,
  input  logic signed [15:0]             gyro_x,
  input  logic signed [15:0]             gyro_y,
  input  logic signed [15:0]             gyro_z,
  input  logic signed [15:0]             mag_x,
  input  logic signed [15:0]             mag_y,
  input  logic signed [15:0]             mag_z,
  input  logic signed [15:0]             temp_raw,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             accel_out_x,
  output logic signed [15:0]             accel_out_y,
  output logic signed [15:0]             accel_out_z,
  output logic signed [15:0]             rate_out_x,
  output logic signed [15:0]             rate_out_y,
  output logic signed [15:0]             rate_out_z,
  output logic signed [15:0]             field_out_x,
  output logic signed [15:0]             field_out_y,
  output logic signed [15:0]             field_out_z,
  output logic signed [15:0]             temp_out,
  output logic                           calib_done
);

  logic [1:0]         accel_range;
  logic [1:0]         gyro_range;
  logic signed [15:0] temp_bias;

  logic signed [15:0] acc_raw [3];
  logic signed [15:0] gyr_raw [3];
  logic signed [15:0] mag_raw [3];
  logic signed [15:0] acc_val [3];
  logic signed [15:0] rate_val [3];
  logic signed [15:0] fld_val [3];
  logic signed [15:0] temp_val;

  imc_pkg::imc_cal_ctl_t ctl;
  imc_pkg::imc_adv_t     adv;
  logic                  busy;
  logic                  accept;
  logic                  v1;
  logic                  v2;
  logic                  v3;
  logic                  d1;
  logic                  d2;
  logic                  d3;
  logic                  free_out;
  logic                  free3;
  logic                  free2;
  logic                  free1;
  logic                  ld_out;

  assign acc_raw = '{accel_x, accel_y, accel_z};
  assign gyr_raw = '{gyro_x, gyro_y, gyro_z};
  assign mag_raw = '{mag_x, mag_y, mag_z};

  always_comb begin
    free_out = !out_valid || out_ready;
    free3    = !v3 || free_out;
    free2    = !v2 || free3;
    free1    = !v1 || free2;
    in_ready = free1 && !busy;
    accept   = in_valid && in_ready;
    adv.s1   = accept;
    adv.s2   = v1 && free2;
    adv.s3   = v2 && free3;
    ld_out   = v3 && free_out;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_range <= '0;
      gyro_range  <= '0;
      temp_bias   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        imc_pkg::REG_ACCEL_RANGE: accel_range <= cfg_data[1:0];
        imc_pkg::REG_GYRO_RANGE:  gyro_range  <= cfg_data[1:0];
        imc_pkg::REG_ROOM_TEMP:   temp_bias   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  imc_cal_ctrl u_cal_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .ctl    (ctl),
    .busy   (busy)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    imc_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .ctl         (ctl),
      .accel_range (accel_range),
      .gyro_range  (gyro_range),
      .accel_raw   (acc_raw[i]),
      .gyro_raw    (gyr_raw[i]),
      .mag_raw     (mag_raw[i]),
      .accel_val   (acc_val[i]),
      .rate_val    (rate_val[i]),
      .field_val   (fld_val[i])
    );
  end

  imc_temp u_temp (
    .clk       (clk),
    .adv       (adv),
    .temp_bias (temp_bias),
    .temp_raw  (temp_raw),
    .temp_val  (temp_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1 <= 1'b1;
      end else if (adv.s2) begin
        v1 <= 1'b0;
      end
      if (adv.s2) begin
        v2 <= 1'b1;
      end else if (adv.s3) begin
        v2 <= 1'b0;
      end
      if (adv.s3) begin
        v3 <= 1'b1;
      end else if (ld_out) begin
        v3 <= 1'b0;
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d1 <= ctl.finish;
    end
    if (adv.s2) begin
      d2 <= d1;
    end
    if (adv.s3) begin
      d3 <= d2;
    end
    if (ld_out) begin
      accel_out_x <= acc_val[0];
      accel_out_y <= acc_val[1];
      accel_out_z <= acc_val[2];
      rate_out_x  <= rate_val[0];
      rate_out_y  <= rate_val[1];
      rate_out_z  <= rate_val[2];
      field_out_x <= fld_val[0];
      field_out_y <= fld_val[1];
      field_out_z <= fld_val[2];
      temp_out    <= temp_val;
      calib_done  <= d3;
    end
  end

endmodule

/* sv/imc_checker.sv */
// Port-level checker for the IMU sample calibrate and scale block, bound to the top level.
// Depends on imu_sample_calibrate_scale_assert.svh.
`include "imu_sample_calibrate_scale_assert.svh"

module imc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] accel_out_x,
  input logic signed [15:0] accel_out_y,
  input logic signed [15:0] accel_out_z,
  input logic signed [15:0] rate_out_x,
  input logic signed [15:0] rate_out_y,
  input logic signed [15:0] rate_out_z,
  input logic signed [15:0] field_out_x,
  input logic signed [15:0] field_out_y,
  input logic signed [15:0] field_out_z,
  input logic signed [15:0] temp_out,
  input logic               calib_done
);

  logic [160:0] out_word;
  logic         rate_ok;

  assign out_word = {accel_out_x, accel_out_y, accel_out_z, rate_out_x, rate_out_y,
                     rate_out_z, field_out_x, field_out_y, field_out_z, temp_out,
                     calib_done};

  assign rate_ok = (rate_out_x != 16'sh8000) && (rate_out_x != 16'sh7fff) &&
                   (rate_out_y != 16'sh8000) && (rate_out_y != 16'sh7fff) &&
                   (rate_out_z != 16'sh8000) && (rate_out_z != 16'sh7fff);

  `IMC_ASSERT_NEXT_NORST(a_reset_empties, clk, rst, !out_valid)

  `IMC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  `IMC_ASSERT_IMPLY(a_rate_bound, clk, rst, out_valid, rate_ok)

endmodule

bind imu_sample_calibrate_scale imc_checker u_imc_checker (.*);
